### rtl/hsv2rgb_pkg.sv
// shared constants and widths for the hsv to rgb pixel converter
package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned FRAC_W = 6;
  localparam int unsigned SEC_W  = 3;

  // hue wraps once at or above a full turn
  localparam logic [HUE_W-1:0] DEG_FULL   = 9'd360;
  localparam logic [HUE_W-1:0] DEG_SECTOR = 9'd60;

  // sector codes, one per 60 degree slice
  localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

  // reciprocal of 15 in 16 fractional bits, rounded up
  localparam logic [12:0] RECIP_15 = 13'd4370;

  typedef logic [CH_W-1:0] chan_t;

endpackage

### rtl/hsv_to_rgb_converter_top.sv
// hsv to rgb pixel converter, five stage pipeline
// each pixel is registered in stages 1 to 4 and then in the output register
// throughput: one pixel per clock, limited by nothing but output stalls
// a stall on a presented output freezes every stage together; the input stall follows it
// synchronous active-low reset clears the stage valid bits only, payload is not reset
module hsv_to_rgb_converter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] in_hue,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  in_saturation,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  in_brightness,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsv2rgb_pkg::CH_W-1:0]  out_red,
  output logic [hsv2rgb_pkg::CH_W-1:0]  out_green,
  output logic [hsv2rgb_pkg::CH_W-1:0]  out_blue
);
  import hsv2rgb_pkg::*;

  // whole pipe moves when the output register is empty or being taken
  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // ---------------------------------------------------------------
  // stage 1: hue wrap, sector search, remainder, s*v product
  // ---------------------------------------------------------------
  logic [HUE_W-1:0]  hue_wrap;
  logic [SEC_W-1:0]  sector_nxt;
  logic [HUE_W-1:0]  sector_base;
  logic [HUE_W-1:0]  rem_full;

  always_comb begin
    hue_wrap = (in_hue >= DEG_FULL) ? (in_hue - DEG_FULL) : in_hue;
    // compare chain against the sector boundaries
    if (hue_wrap < 9'd60) begin
      sector_nxt  = SEC_RED_YEL;
      sector_base = 9'd0;
    end else if (hue_wrap < 9'd120) begin
      sector_nxt  = SEC_YEL_GRN;
      sector_base = 9'd60;
    end else if (hue_wrap < 9'd180) begin
      sector_nxt  = SEC_GRN_CYN;
      sector_base = 9'd120;
    end else if (hue_wrap < 9'd240) begin
      sector_nxt  = SEC_CYN_BLU;
      sector_base = 9'd180;
    end else if (hue_wrap < 9'd300) begin
      sector_nxt  = SEC_BLU_MAG;
      sector_base = 9'd240;
    end else begin
      sector_nxt  = SEC_MAG_RED;
      sector_base = 9'd300;
    end
    rem_full = hue_wrap - sector_base;
  end

  logic                  s1_valid_r;
  logic [SEC_W-1:0]      s1_sector_r;
  logic [FRAC_W-1:0]     s1_rem_r;
  logic [2*CH_W-1:0]     s1_prod_r;
  chan_t                 s1_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sector_r <= sector_nxt;
      s1_rem_r    <= rem_full[FRAC_W-1:0];
      s1_prod_r   <= in_saturation * in_brightness;
      s1_bright_r <= in_brightness;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: chroma = product / 255, pick the ramp numerator
  // ---------------------------------------------------------------
  // floor(p/255) = (p + 1 + (p >> 8)) >> 8, exact for any 16-bit product of two bytes
  logic [2*CH_W:0]  div255_sum;
  chan_t            chroma_nxt;
  logic [FRAC_W-1:0] num_nxt;

  always_comb begin
    div255_sum = {1'b0, s1_prod_r} + {{CH_W{1'b0}}, 1'b0, s1_prod_r[2*CH_W-1:CH_W]}
                 + {{2*CH_W{1'b0}}, 1'b1};
    chroma_nxt = div255_sum[2*CH_W-1:CH_W];
    // falling ramp in odd sectors
    num_nxt    = s1_sector_r[0] ? (DEG_SECTOR[FRAC_W-1:0] - s1_rem_r) : s1_rem_r;
  end

  logic              s2_valid_r;
  logic [SEC_W-1:0]  s2_sector_r;
  logic [FRAC_W-1:0] s2_num_r;
  chan_t             s2_chroma_r;
  chan_t             s2_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sector_r <= s1_sector_r;
      s2_num_r    <= num_nxt;
      s2_chroma_r <= chroma_nxt;
      s2_bright_r <= s1_bright_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: chroma * numerator, offset m = v - c
  // ---------------------------------------------------------------
  logic              s3_valid_r;
  logic [SEC_W-1:0]  s3_sector_r;
  logic [CH_W+FRAC_W-1:0] s3_ramp_r;
  chan_t             s3_chroma_r;
  chan_t             s3_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sector_r <= s2_sector_r;
      s3_ramp_r   <= s2_chroma_r * s2_num_r;
      s3_chroma_r <= s2_chroma_r;
      // chroma never exceeds brightness, so no underflow
      s3_offset_r <= s2_bright_r - s2_chroma_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: x = ramp / 60 as (ramp >> 2) / 15 by reciprocal multiply
  // ---------------------------------------------------------------
  // quarter ramp stays below 3826, where the rounded-up reciprocal is exact
  logic [CH_W+FRAC_W-3:0] ramp_q;
  logic [CH_W+FRAC_W+10:0] recip_prod;

  assign ramp_q     = s3_ramp_r[CH_W+FRAC_W-1:2];
  assign recip_prod = ramp_q * RECIP_15;

  logic             s4_valid_r;
  logic [SEC_W-1:0] s4_sector_r;
  chan_t            s4_x_r;
  chan_t            s4_chroma_r;
  chan_t            s4_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (advance) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_sector_r <= s3_sector_r;
      s4_x_r      <= recip_prod[23:16];
      s4_chroma_r <= s3_chroma_r;
      s4_offset_r <= s3_offset_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 5: place (c, x, 0) by sector and add the offset
  // ---------------------------------------------------------------
  chan_t red_base, green_base, blue_base;

  always_comb begin
    case (s4_sector_r)
      SEC_RED_YEL: begin
        red_base = s4_chroma_r; green_base = s4_x_r;      blue_base = '0;
      end
      SEC_YEL_GRN: begin
        red_base = s4_x_r;      green_base = s4_chroma_r; blue_base = '0;
      end
      SEC_GRN_CYN: begin
        red_base = '0;          green_base = s4_chroma_r; blue_base = s4_x_r;
      end
      SEC_CYN_BLU: begin
        red_base = '0;          green_base = s4_x_r;      blue_base = s4_chroma_r;
      end
      SEC_BLU_MAG: begin
        red_base = s4_x_r;      green_base = '0;          blue_base = s4_chroma_r;
      end
      default: begin
        red_base = s4_chroma_r; green_base = '0;          blue_base = s4_x_r;
      end
    endcase
  end

  logic  out_valid_r;
  chan_t out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s4_valid_r;
    end
  end

  // sums stay within a byte since c + m equals brightness
  always_ff @(posedge clk) begin
    if (advance) begin
      out_red_r   <= red_base + s4_offset_r;
      out_green_r <= green_base + s4_offset_r;
      out_blue_r  <= blue_base + s4_offset_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

### rtl/hsv2rgb_checker.sv
// port-level assertions for the hsv to rgb converter, bound to the top level
module hsv2rgb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [hsv2rgb_pkg::HUE_W-1:0] in_hue,
  input logic [hsv2rgb_pkg::CH_W-1:0]  in_saturation,
  input logic [hsv2rgb_pkg::CH_W-1:0]  in_brightness,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hsv2rgb_pkg::CH_W-1:0]  out_red,
  input logic [hsv2rgb_pkg::CH_W-1:0]  out_green,
  input logic [hsv2rgb_pkg::CH_W-1:0]  out_blue
);
  import hsv2rgb_pkg::*;

  // input is held off exactly when a result sits stalled at the output
  a_stall_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track the stalled output");

  // nothing comes out right after reset
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // a stalled result stays presented
  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // a stalled result keeps its colour
  a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  // a held-off input transaction stays offered with the same pixel
  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_hue) && $stable(in_saturation)
      && $stable(in_brightness))
    else $error("stalled input transaction changed");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
